// ===== hdl/crc32ms_pkg.sv =====
// shared types, constants and crc tables for the multi-stream reflected crc-32
// no dependencies
`default_nettype none

package crc32ms_pkg;

    localparam int unsigned STREAMS        = 3;
    localparam int unsigned BYTES_PER_ITEM = 8;
    localparam int unsigned STREAM_W       = 2;
    localparam int unsigned CNT_W          = 4;
    localparam int unsigned DATA_W         = 8 * BYTES_PER_ITEM;
    localparam int unsigned CRC_W          = 32;
    localparam logic [CRC_W-1:0] CRC_POLY  = 32'hEDB88320;

    typedef logic [CRC_W-1:0]    t_crc;
    typedef logic [STREAM_W-1:0] t_stream;
    typedef logic [CNT_W-1:0]    t_cnt;

    // one crc column per input bit of a byte
    typedef t_crc [7:0]                       t_byte_cols;
    typedef t_byte_cols [BYTES_PER_ITEM-1:0]  t_lane_tab;
    typedef t_crc [CRC_W-1:0]                 t_crc_cols;
    typedef t_crc_cols [BYTES_PER_ITEM:0]     t_adv_tab;

    // transaction held between the lane stage and the state update
    typedef struct packed {
        t_stream stream;
        logic    start_req;
        t_crc    seed;
        t_cnt    cnt;
        logic    last;
        t_crc    dpart;
    } t_item;

    typedef struct packed {
        t_stream result_stream;
        t_crc    checksum;
    } t_result;

    // plain lsb-first shift register steps, used at elaboration only
    function automatic t_crc bit_steps(input t_crc c_in, input int unsigned steps);
        t_crc c;
        c = c_in;
        for (int unsigned s = 0; s < steps; s++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

    // lane j sees padded byte j; it is followed by the remaining bytes of the word
    function automatic t_lane_tab build_lane_tab();
        t_lane_tab t;
        for (int unsigned j = 0; j < BYTES_PER_ITEM; j++) begin
            for (int unsigned k = 0; k < 8; k++) begin
                t[j][k] = bit_steps(t_crc'(1) << k, 8 * (BYTES_PER_ITEM - j));
            end
        end
        return t;
    endfunction

    // advance of the running crc over n zero bytes
    function automatic t_adv_tab build_adv_tab();
        t_adv_tab t;
        for (int unsigned n = 0; n <= BYTES_PER_ITEM; n++) begin
            for (int unsigned k = 0; k < CRC_W; k++) begin
                t[n][k] = bit_steps(t_crc'(1) << k, 8 * n);
            end
        end
        return t;
    endfunction

    localparam t_lane_tab LANE_TAB = build_lane_tab();
    localparam t_adv_tab  ADV_TAB  = build_adv_tab();

endpackage

`default_nettype wire

// ===== hdl/crc32ms_if.sv =====
// valid/ready channel interfaces for input items and results
// depends on crc32ms_pkg
`default_nettype none

interface crc32ms_in_if;
    logic                                   valid;
    logic                                   ready;
    crc32ms_pkg::t_stream                   stream;
    logic                                   start_req;
    crc32ms_pkg::t_crc                      seed;
    logic [crc32ms_pkg::DATA_W-1:0]         data;
    crc32ms_pkg::t_cnt                      byte_count;
    logic                                   last;

    modport source (output valid, stream, start_req, seed, data, byte_count, last,
                    input ready);
    modport sink   (input valid, stream, start_req, seed, data, byte_count, last,
                    output ready);
endinterface

interface crc32ms_out_if;
    logic                 valid;
    logic                 ready;
    crc32ms_pkg::t_stream result_stream;
    crc32ms_pkg::t_crc    checksum;

    modport source (output valid, result_stream, checksum, input ready);
    modport sink   (input valid, result_stream, checksum, output ready);
endinterface

`default_nettype wire

// ===== hdl/crc32ms_lane.sv =====
// one byte lane: crc contribution of a single padded data byte
// depends on crc32ms_pkg
`default_nettype none

module crc32ms_lane (
    input  wire logic [7:0]              i_byte,
    input  wire crc32ms_pkg::t_byte_cols i_cols,
    output crc32ms_pkg::t_crc            o_part
);

    always_comb begin
        o_part = '0;
        for (int k = 0; k < 8; k++) begin
            if (i_byte[k]) begin
                o_part = o_part ^ i_cols[k];
            end
        end
    end

endmodule

`default_nettype wire

// ===== hdl/crc32ms_merge.sv =====
// per-stream crc registers; merges the lane sum with the advanced running crc
// depends on crc32ms_pkg
`default_nettype none

module crc32ms_merge (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_fire,
    input  wire crc32ms_pkg::t_item   i_item,
    output logic                      o_push,
    output crc32ms_pkg::t_result      o_res
);

    crc32ms_pkg::t_crc r_crc [crc32ms_pkg::STREAMS];
    crc32ms_pkg::t_crc w_cur;
    crc32ms_pkg::t_crc w_adv;
    crc32ms_pkg::t_crc n_crc;
    logic              w_hit;

    always_comb begin
        w_cur = '0;
        w_hit = 1'b0;
        for (int s = 0; s < int'(crc32ms_pkg::STREAMS); s++) begin
            if (i_item.stream == crc32ms_pkg::STREAM_W'(s)) begin
                w_cur = r_crc[s];
                w_hit = 1'b1;
            end
        end
        if (i_item.start_req) begin
            w_cur = i_item.seed;
        end
        // shift the starting crc past the item's bytes, then fold in the data
        w_adv = '0;
        for (int k = 0; k < int'(crc32ms_pkg::CRC_W); k++) begin
            if (w_cur[k]) begin
                w_adv = w_adv ^ crc32ms_pkg::ADV_TAB[i_item.cnt][k];
            end
        end
        n_crc = w_adv ^ i_item.dpart;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < int'(crc32ms_pkg::STREAMS); s++) begin
                r_crc[s] <= '0;
            end
        end else if (i_fire) begin
            for (int s = 0; s < int'(crc32ms_pkg::STREAMS); s++) begin
                if (i_item.stream == crc32ms_pkg::STREAM_W'(s)) begin
                    r_crc[s] <= n_crc;
                end
            end
        end
    end

    assign o_push              = i_fire && w_hit && i_item.last;
    assign o_res.result_stream = i_item.stream;
    assign o_res.checksum      = n_crc;

endmodule

`default_nettype wire

// ===== hdl/crc32ms_outbuf.sv =====
// result register with one skid entry; full flag is registered
// depends on crc32ms_pkg
`default_nettype none

module crc32ms_outbuf (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_push,
    input  wire crc32ms_pkg::t_result i_res,
    input  wire logic                 i_ready,
    output logic                      o_valid,
    output crc32ms_pkg::t_result      o_res,
    output logic                      o_full
);

    logic                 r_out_valid;
    logic                 r_skid_valid;
    crc32ms_pkg::t_result r_out;
    crc32ms_pkg::t_result r_skid;
    logic                 w_pop;

    assign w_pop = r_out_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || w_pop) begin
            // no push arrives while the skid entry is occupied
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid  <= i_push;
            end
        end else if (i_push) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || w_pop) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (i_push) begin
                r_out <= i_res;
            end
        end else if (i_push) begin
            r_skid <= i_res;
        end
    end

    assign o_valid = r_out_valid;
    assign o_res   = r_out;
    assign o_full  = r_skid_valid;

endmodule

`default_nettype wire

// ===== hdl/crc32_reflected_multi_stream.sv =====
// multi-stream reflected crc-32: one transaction of up to eight bytes per cycle while
// the result buffer is not full. a last transaction is registered in the lane stage and
// then, once the result buffer has room, its checksum is registered in the result buffer.
// the lane xor tree and the state update (32-column advance of the running crc) each
// take one register stage.
// reset clears all running crcs to zero and empties the pipeline and result buffer.
`default_nettype none

module crc32_reflected_multi_stream (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    crc32ms_in_if.sink   i_in,
    crc32ms_out_if.source o_out
);

    localparam int unsigned NB = crc32ms_pkg::BYTES_PER_ITEM;

    crc32ms_pkg::t_cnt                 w_cnt;
    crc32ms_pkg::t_cnt                 w_pad_bytes;
    logic [crc32ms_pkg::DATA_W-1:0]    w_pad;
    crc32ms_pkg::t_crc                 w_part [NB];
    crc32ms_pkg::t_crc                 w_dsum;
    logic                              w_accept;
    logic                              w_fire;
    logic                              w_full;
    logic                              w_push;
    crc32ms_pkg::t_result              w_res;
    crc32ms_pkg::t_result              w_out_res;
    logic                              r_s1_valid;
    crc32ms_pkg::t_item                r_s1;

    // clamp the count, then right-align the bytes so every lane has a fixed weight
    always_comb begin
        if (i_in.byte_count > crc32ms_pkg::CNT_W'(NB)) begin
            w_cnt = crc32ms_pkg::CNT_W'(NB);
        end else begin
            w_cnt = i_in.byte_count;
        end
        w_pad_bytes = crc32ms_pkg::CNT_W'(NB) - w_cnt;
        w_pad       = i_in.data << {w_pad_bytes, 3'b000};
    end

    for (genvar g = 0; g < NB; g++) begin : g_lane
        crc32ms_lane u_lane (
            .i_byte (w_pad[8*g +: 8]),
            .i_cols (crc32ms_pkg::LANE_TAB[g]),
            .o_part (w_part[g])
        );
    end

    always_comb begin
        w_dsum = '0;
        for (int j = 0; j < int'(NB); j++) begin
            w_dsum = w_dsum ^ w_part[j];
        end
    end

    assign i_in.ready = !r_s1_valid || !w_full;
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_fire     = r_s1_valid && !w_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_accept) begin
            r_s1_valid <= 1'b1;
        end else if (w_fire) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1.stream    <= i_in.stream;
            r_s1.start_req <= i_in.start_req;
            r_s1.seed      <= i_in.seed;
            r_s1.cnt       <= w_cnt;
            r_s1.last      <= i_in.last;
            r_s1.dpart     <= w_dsum;
        end
    end

    crc32ms_merge u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (w_fire),
        .i_item  (r_s1),
        .o_push  (w_push),
        .o_res   (w_res)
    );

    crc32ms_outbuf u_outbuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_res   (w_res),
        .i_ready (o_out.ready),
        .o_valid (o_out.valid),
        .o_res   (w_out_res),
        .o_full  (w_full)
    );

    assign o_out.result_stream = w_out_res.result_stream;
    assign o_out.checksum      = w_out_res.checksum;

endmodule

`default_nettype wire

// ===== test/crc32_reflected_multi_stream_tb.sv =====
// self-checking testbench for the multi-stream reflected crc-32 block
// depends on crc32ms_pkg, crc32ms_in_if, crc32ms_out_if and crc32_reflected_multi_stream

// tracks the running crc of each stream and the block checksums still owed
class block_crc_tracker;
    crc32ms_pkg::t_crc    running_crc [crc32ms_pkg::STREAMS];
    crc32ms_pkg::t_result awaited_sums [$];
    int unsigned          mismatches;

    function new();
        foreach (running_crc[s]) running_crc[s] = '0;
        mismatches = 0;
    endfunction

    function void note_transaction(crc32ms_pkg::t_stream s, logic start,
                                   crc32ms_pkg::t_crc seed,
                                   logic [crc32ms_pkg::DATA_W-1:0] data,
                                   crc32ms_pkg::t_cnt cnt, logic last);
        crc32ms_pkg::t_crc    c;
        int unsigned          n;
        crc32ms_pkg::t_result r;
        if (s >= crc32ms_pkg::STREAMS) return;
        c = start ? seed : running_crc[s];
        n = (cnt > crc32ms_pkg::BYTES_PER_ITEM) ? crc32ms_pkg::BYTES_PER_ITEM : cnt;
        // low byte first, each byte shifted out lsb first
        for (int unsigned i = 0; i < n; i++) begin
            c ^= crc32ms_pkg::t_crc'(data[8*i +: 8]);
            for (int k = 0; k < 8; k++) begin
                c = c[0] ? ((c >> 1) ^ crc32ms_pkg::CRC_POLY) : (c >> 1);
            end
        end
        running_crc[s] = c;
        if (last) begin
            r.result_stream = s;
            r.checksum      = c;
            awaited_sums.push_back(r);
        end
    endfunction

    function void check_result(crc32ms_pkg::t_stream s, crc32ms_pkg::t_crc sum);
        crc32ms_pkg::t_result want;
        if (awaited_sums.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected result: stream %0d checksum %08h", s, sum);
            return;
        end
        want = awaited_sums.pop_front();
        if (want.result_stream !== s || want.checksum !== sum) begin
            mismatches++;
            if (mismatches <= 10)
                $display({"mismatch: expected stream %0d checksum %08h, ",
                          "got stream %0d checksum %08h"},
                         want.result_stream, want.checksum, s, sum);
        end
    endfunction

    function int unsigned outstanding();
        return awaited_sums.size();
    endfunction
endclass

module crc32_reflected_multi_stream_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned          CYCLE_LIMIT   = 400000;
    localparam int unsigned          SETTLE_CYCLES = 8;
    localparam crc32ms_pkg::t_stream NO_STREAM     =
        crc32ms_pkg::t_stream'(crc32ms_pkg::STREAMS);
    localparam crc32ms_pkg::t_cnt    FULL_CNT      =
        crc32ms_pkg::t_cnt'(crc32ms_pkg::BYTES_PER_ITEM);

    logic             clk;
    logic             rst_n;
    int unsigned      src_idle_pct;
    int unsigned      snk_idle_pct;
    int unsigned      cycle_count;
    bit               block_open [crc32ms_pkg::STREAMS];
    block_crc_tracker tracker;

    crc32ms_in_if  in_ch ();
    crc32ms_out_if out_ch ();

    crc32_reflected_multi_stream i_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // returns at the edge where the transaction is taken
    task automatic send(crc32ms_pkg::t_stream s, logic start, crc32ms_pkg::t_crc seed,
                        logic [crc32ms_pkg::DATA_W-1:0] data, crc32ms_pkg::t_cnt cnt,
                        logic last);
        bit took;
        while ($urandom_range(99) < src_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.stream     <= s;
        in_ch.start_req  <= start;
        in_ch.seed       <= seed;
        in_ch.data       <= data;
        in_ch.byte_count <= cnt;
        in_ch.last       <= last;
        do begin
            @(negedge clk);
            took = in_ch.ready;
            @(posedge clk);
        end while (!took);
    endtask

    task automatic wait_for_results();
        in_ch.valid <= 1'b0;
        do @(posedge clk); while (tracker.outstanding() != 0);
    endtask

    // mostly well-formed interleaved blocks, with restarts and ignored items mixed in
    task automatic send_random_traffic(int unsigned n_items);
        int unsigned          sent;
        int unsigned          roll;
        crc32ms_pkg::t_stream s;
        logic                 start;
        crc32ms_pkg::t_crc    seed;
        crc32ms_pkg::t_cnt    cnt;
        logic                 last;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(99) < 3) begin
                send(NO_STREAM, 1'($urandom_range(1)), $urandom, {$urandom, $urandom},
                     crc32ms_pkg::t_cnt'($urandom_range(15)), 1'($urandom_range(1)));
            end else begin
                s     = crc32ms_pkg::t_stream'($urandom_range(crc32ms_pkg::STREAMS - 1));
                start = block_open[s] ? ($urandom_range(29) == 0) : ($urandom_range(19) != 0);
                roll  = $urandom_range(99);
                if (roll < 60) begin
                    cnt = FULL_CNT;
                end else if (roll < 90) begin
                    cnt = crc32ms_pkg::t_cnt'(
                        $urandom_range(crc32ms_pkg::BYTES_PER_ITEM - 1, 1));
                end else if (roll < 95) begin
                    cnt = '0;
                end else begin
                    cnt = crc32ms_pkg::t_cnt'(
                        $urandom_range(15, crc32ms_pkg::BYTES_PER_ITEM + 1));
                end
                roll = $urandom_range(99);
                seed = (roll < 5) ? '0 : (roll < 10) ? '1 : crc32ms_pkg::t_crc'($urandom);
                last = ($urandom_range(3) == 0);
                block_open[s] = !last;
                send(s, start, seed, {$urandom, $urandom}, cnt, last);
                sent++;
            end
        end
    endtask

    // handshakes are sampled at the falling edge before the rising edge that takes them
    always @(negedge clk) begin
        if (rst_n) begin
            if (in_ch.valid && in_ch.ready)
                tracker.note_transaction(in_ch.stream, in_ch.start_req, in_ch.seed,
                                         in_ch.data, in_ch.byte_count, in_ch.last);
            if (out_ch.valid && out_ch.ready)
                tracker.check_result(out_ch.result_stream, out_ch.checksum);
        end
    end

    initial begin
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            out_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("** crc32_reflected_multi_stream: FAILED **");
        $finish;
    end

    initial begin
        tracker          = new();
        src_idle_pct     = 11;
        snk_idle_pct     = 74;
        rst_n            <= 1'b0;
        in_ch.valid      <= 1'b0;
        in_ch.stream     <= '0;
        in_ch.start_req  <= 1'b0;
        in_ch.seed       <= '0;
        in_ch.data       <= '0;
        in_ch.byte_count <= '0;
        in_ch.last       <= 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // empty block and the seed extremes
        send(2'd0, 1'b1, '0, '0, '0, 1'b1);
        send(2'd1, 1'b1, '1, '1, FULL_CNT, 1'b1);
        send(2'd2, 1'b1, '0, '0, FULL_CNT, 1'b1);
        // "123456789" over two transactions, seed ignored on the second
        send(2'd0, 1'b1, '1, 64'h3837363534333231, FULL_CNT, 1'b0);
        send(2'd0, 1'b0, crc32ms_pkg::t_crc'($urandom), 64'h39, 4'd1, 1'b1);
        // out-of-range stream leaves everything alone
        send(NO_STREAM, 1'b1, crc32ms_pkg::t_crc'($urandom), {$urandom, $urandom},
             4'd8, 1'b1);
        send(NO_STREAM, 1'b0, '1, '1, 4'd15, 1'b0);
        // oversized counts, interleaved blocks
        send(2'd1, 1'b1, 32'h12345678, 64'hAAAA_AAAA_AAAA_AAAA, 4'd15, 1'b0);
        send(2'd2, 1'b1, '1, 64'h5555_5555_5555_5555, 4'd9, 1'b0);
        send(2'd1, 1'b0, crc32ms_pkg::t_crc'($urandom), 64'h0123_4567_89AB_CDEF, 4'd3, 1'b0);
        send(2'd2, 1'b0, crc32ms_pkg::t_crc'($urandom), {$urandom, $urandom}, '0, 1'b1);
        send(2'd1, 1'b0, crc32ms_pkg::t_crc'($urandom), {$urandom, $urandom}, FULL_CNT,
             1'b1);
        // carry on after last without a new seed
        send(2'd2, 1'b0, crc32ms_pkg::t_crc'($urandom), {$urandom, $urandom}, 4'd4, 1'b1);
        send(2'd0, 1'b0, crc32ms_pkg::t_crc'($urandom), {$urandom, $urandom}, '0, 1'b1);
        // restart in the middle of a block
        send(2'd0, 1'b1, '0, {$urandom, $urandom}, FULL_CNT, 1'b0);
        send(2'd0, 1'b1, '1, {$urandom, $urandom}, 4'd2, 1'b1);
        send(2'd1, 1'b1, '0, 64'h8000_0000_0000_0080, 4'd1, 1'b1);
        send(2'd2, 1'b1, '0, 64'h1, 4'd1, 1'b1);
        send(2'd1, 1'b1, crc32ms_pkg::t_crc'($urandom), 64'hFFFF_FFFF_FFFF_FFFF, 4'd7, 1'b1);
        wait_for_results();

        for (int phase = 0; phase < 3; phase++) begin
            if (phase == 1) begin
                src_idle_pct = 74;
                snk_idle_pct = 11;
            end else if (phase == 2) begin
                src_idle_pct = 0;
                snk_idle_pct = 0;
            end
            send_random_traffic(225);
            wait_for_results();
            send_random_traffic(225);
            wait_for_results();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (tracker.mismatches == 0 && tracker.outstanding() == 0) begin
            $display("** crc32_reflected_multi_stream: PASSED **");
        end else begin
            $display("** crc32_reflected_multi_stream: FAILED **");
        end
        $finish;
    end

endmodule
